// ===== rtl/sof_pkg.sv =====
// shared constants, codes and types for the substring occurrence finder
`default_nettype none

package sof_pkg;

    localparam int TOKEN_MAX   = 16;
    localparam int TEXT_MAX    = 65536;

    localparam int CP_W        = 21;
    localparam int CFG_W       = 16;
    localparam int POS_W       = 17;
    localparam int CNT_W       = 17;
    localparam int TOKEN_LEN_W = $clog2(TOKEN_MAX + 1);
    localparam int IDX_W       = $clog2(TEXT_MAX + 1);
    localparam int CMP_W       = (IDX_W > CFG_W) ? IDX_W : CFG_W;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // action codes
    localparam logic [1:0] ACT_TOKEN  = 2'd0;
    localparam logic [1:0] ACT_TEXT   = 2'd1;
    localparam logic [1:0] ACT_REPORT = 2'd2;

    // register indexes
    localparam logic [1:0] REG_OVERLAP = 2'd0;
    localparam logic [1:0] REG_START   = 2'd1;
    localparam logic [1:0] REG_NTH     = 2'd2;

    typedef struct packed {
        logic             overlap_mode;
        logic [CFG_W-1:0] start_index;
        logic [CFG_W-1:0] nth_find;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] match_count;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/sof_cell.sv =====
// one window cell: a text character, the token character it lines up with, and its compare
`default_nettype none

module sof_cell
    import sof_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            txt_shift,
    input  wire logic            tok_shift,
    input  wire logic [CP_W-1:0] txt_in,
    input  wire logic [CP_W-1:0] tok_in,
    input  wire logic            active,
    input  wire logic            ok_in,
    output logic      [CP_W-1:0] txt_out,
    output logic      [CP_W-1:0] tok_out,
    output logic                 ok_out
);

    logic [CP_W-1:0] txt_reg;
    logic [CP_W-1:0] txt_next;
    logic [CP_W-1:0] tok_reg;
    logic [CP_W-1:0] tok_next;

    always_comb
    begin
        txt_next = txt_shift ? txt_in : txt_reg;
        tok_next = tok_shift ? tok_in : tok_reg;
    end

    always_ff @(posedge clk)
    begin
        txt_reg <= txt_next;
        tok_reg <= tok_next;
    end

    assign txt_out = txt_reg;
    assign tok_out = tok_reg;

    // compare against the character this cell will hold once the text beat shifts in
    assign ok_out = ok_in & (~active | (txt_in == tok_reg));

endmodule

`default_nettype wire

// ===== rtl/sof_tally.sv =====
// text position, skip window and match counters, plus the report value
`default_nettype none

module sof_tally
    import sof_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   text_beat,
    input  wire logic                   report_beat,
    input  wire logic                   window_ok,
    input  wire logic [TOKEN_LEN_W-1:0] token_len,
    input  wire cfg_t                   cfg,
    output result_t                     result
);

    logic [IDX_W-1:0]       char_idx_reg;
    logic [IDX_W-1:0]       char_idx_next;
    logic [TOKEN_LEN_W-1:0] skip_reg;
    logic [TOKEN_LEN_W-1:0] skip_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       after_reg;
    logic [CNT_W-1:0]       after_next;
    logic [IDX_W-1:0]       found_pos_reg;
    logic [IDX_W-1:0]       found_pos_next;
    logic                   found_reg;
    logic                   found_next;
    logic                   any_reg;
    logic                   any_next;

    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] match_pos;
    logic [CNT_W-1:0] after_inc;
    logic             hit;

    always_comb
    begin
        idx_inc   = char_idx_reg + IDX_W'(1);
        match_pos = idx_inc - IDX_W'(token_len);
        after_inc = (after_reg != CNT_MAX) ? after_reg + CNT_W'(1) : after_reg;
        hit       = window_ok && (token_len != '0) && (idx_inc >= IDX_W'(token_len));
    end

    always_comb
    begin
        char_idx_next  = char_idx_reg;
        skip_next      = skip_reg;
        count_next     = count_reg;
        after_next     = after_reg;
        found_pos_next = found_pos_reg;
        found_next     = found_reg;
        any_next       = any_reg;
        priority if (report_beat)
        begin
            char_idx_next  = '0;
            skip_next      = '0;
            count_next     = '0;
            after_next     = '0;
            found_pos_next = '0;
            found_next     = 1'b0;
            any_next       = 1'b0;
        end
        else if (text_beat && (char_idx_reg < IDX_W'(TEXT_MAX)))
        begin
            char_idx_next = idx_inc;
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - TOKEN_LEN_W'(1);
            end
            else if (hit)
            begin
                any_next  = 1'b1;
                skip_next = cfg.overlap_mode ? '0 : token_len - TOKEN_LEN_W'(1);
                if ((CMP_W'(match_pos) >= CMP_W'(cfg.start_index)) && (count_reg != CNT_MAX))
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (CMP_W'(match_pos) > CMP_W'(cfg.start_index))
                begin
                    after_next = after_inc;
                    if (!found_reg && (after_inc == CNT_W'(cfg.nth_find)))
                    begin
                        found_next     = 1'b1;
                        found_pos_next = match_pos;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_idx_reg  <= '0;
            skip_reg      <= '0;
            count_reg     <= '0;
            after_reg     <= '0;
            found_pos_reg <= '0;
            found_reg     <= 1'b0;
            any_reg       <= 1'b0;
        end
        else
        begin
            char_idx_reg  <= char_idx_next;
            skip_reg      <= skip_next;
            count_reg     <= count_next;
            after_reg     <= after_next;
            found_pos_reg <= found_pos_next;
            found_reg     <= found_next;
            any_reg       <= any_next;
        end
    end

    // all ones on position means too few matches after the start index
    always_comb
    begin
        if (!any_reg || (cfg.nth_find == '0))
        begin
            result.position = '0;
        end
        else if (found_reg)
        begin
            result.position = POS_W'(found_pos_reg);
        end
        else
        begin
            result.position = '1;
        end
        result.match_count = count_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/substring_occurrence_finder.sv =====
// top level: token and text window cell row, handshakes, registers and result stage
// Unless stalled, one beat of any kind is taken every cycle. A text character is
// shifted into a row of sixteen cells; each cell compares the character it is about
// to hold with its token character, and the pass/fail ripples down the row within the
// beat's own cycle, so a match is counted in the cycle the character is accepted.
// A report beat yields one result beat in the next cycle, held in an output register;
// input is taken while that register is empty or being drained, so a stalled result
// blocks input only while out_ready is low. Token characters shift into the same row,
// newest at the head, and only the first token-length cells take part in the compare.
`default_nettype none

module substring_occurrence_finder
    import sof_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       action,
    input  wire logic [CP_W-1:0]  code_point,
    input  wire logic             restart_token,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [POS_W-1:0] position,
    output logic      [CNT_W-1:0] match_count
);

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    logic [TOKEN_LEN_W-1:0] token_len_reg;
    logic [TOKEN_LEN_W-1:0] token_len_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                out_reg;
    result_t                out_next;

    logic    in_beat;
    logic    token_beat;
    logic    text_beat;
    logic    report_beat;
    logic    tok_shift;
    logic    window_ok;
    result_t tally_result;

    logic [CP_W-1:0] txt_q [TOKEN_MAX];
    logic [CP_W-1:0] tok_q [TOKEN_MAX];
    logic            ok_q  [TOKEN_MAX];

    assign in_ready    = !out_valid_reg || out_ready;
    assign in_beat     = in_valid && in_ready;
    assign token_beat  = in_beat && (action == ACT_TOKEN);
    assign text_beat   = in_beat && (action == ACT_TEXT);
    assign report_beat = in_beat && (action == ACT_REPORT);

    // a full token ignores further characters unless restarted
    assign tok_shift = token_beat
                    && (restart_token || (token_len_reg < TOKEN_LEN_W'(TOKEN_MAX)));

    always_comb
    begin
        token_len_next = token_len_reg;
        if (tok_shift)
        begin
            token_len_next = restart_token ? TOKEN_LEN_W'(1)
                                           : token_len_reg + TOKEN_LEN_W'(1);
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_OVERLAP: cfg_next.overlap_mode = cfg_data[0];
                REG_START:   cfg_next.start_index  = cfg_data;
                REG_NTH:     cfg_next.nth_find     = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    genvar j;
    generate
        for (j = 0; j < TOKEN_MAX; j++)
        begin : g_cell
            logic [CP_W-1:0] txt_in;
            logic [CP_W-1:0] tok_in;
            logic            ok_in;

            if (j == 0)
            begin : g_head
                assign txt_in = code_point;
                assign tok_in = code_point;
                assign ok_in  = 1'b1;
            end
            else
            begin : g_body
                assign txt_in = txt_q[j-1];
                assign tok_in = tok_q[j-1];
                assign ok_in  = ok_q[j-1];
            end

            sof_cell u_cell (
                .clk       (clk),
                .txt_shift (text_beat),
                .tok_shift (tok_shift),
                .txt_in    (txt_in),
                .tok_in    (tok_in),
                .active    (TOKEN_LEN_W'(j) < token_len_reg),
                .ok_in     (ok_in),
                .txt_out   (txt_q[j]),
                .tok_out   (tok_q[j]),
                .ok_out    (ok_q[j])
            );
        end
    endgenerate

    assign window_ok = ok_q[TOKEN_MAX-1];

    sof_tally u_tally (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_beat   (text_beat),
        .report_beat (report_beat),
        .window_ok   (window_ok),
        .token_len   (token_len_reg),
        .cfg         (cfg_reg),
        .result      (tally_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (report_beat)
        begin
            out_valid_next = 1'b1;
            out_next       = tally_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.overlap_mode <= 1'b0;
            cfg_reg.start_index  <= '0;
            cfg_reg.nth_find     <= CFG_W'(1);
            token_len_reg        <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            token_len_reg <= token_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign position    = out_reg.position;
    assign match_count = out_reg.match_count;

    a_token_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        token_len_reg <= TOKEN_LEN_W'(TOKEN_MAX))
        else $error("token length beyond row size");

    a_report_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        report_beat |=> out_valid)
        else $error("report beat gave no result beat");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled with the result stage free");

    a_restart_len_one: assert property (@(posedge clk) disable iff (!rst_n)
        (token_beat && restart_token) |=> (token_len_reg == TOKEN_LEN_W'(1)))
        else $error("token restart did not leave one character");

endmodule

`default_nettype wire
